/* hw/rtl/las_pkg.sv */
// las_pkg: shared types, constants and rule functions of the life stencil core
// no dependencies; compiled first

package las_pkg;

  localparam int COORD_W   = 10;
  localparam int SIZE_CFG_W = 11;
  localparam int SIZE_W    = 17;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0]  REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [SIZE_CFG_W-1:0] GRID_SIZE_RESET = SIZE_CFG_W'(1024);

  typedef enum logic [1:0] {
    SLOT_UP_LEFT  = 2'd0,
    SLOT_UP_HERE  = 2'd1,
    SLOT_CUR_LEFT = 2'd2,
    SLOT_CUR_HERE = 2'd3
  } res_slot_t;

  typedef struct packed {
    logic [3:0]         mask;
    logic [3:0]         val;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] row_m1;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] col_m1;
  } res_bundle_t;

  localparam int BORN_COUNT    = 3;
  localparam int SURVIVE_COUNT = 2;

  function automatic logic life_rule(input logic [8:0] w);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        cnt = cnt + {3'd0, w[i]};
      end
    end
    return (cnt == 4'(BORN_COUNT)) || (w[4] && (cnt == 4'(SURVIVE_COUNT)));
  endfunction

  // every column moves down one row, bottom row becomes dead
  function automatic logic [8:0] shift_down(input logic [8:0] w);
    return (w >> 1) & 9'h0DB;
  endfunction

endpackage

/* hw/rtl/las_if.sv */
// las_if: valid/ready channel interfaces for cells, results and config writes
// depends on las_pkg

interface las_cell_if;
  logic valid;
  logic ready;
  logic cell_in;

  modport source (output valid, output cell_in, input ready);
  modport sink (input valid, input cell_in, output ready);
endinterface

interface las_res_if;
  import las_pkg::*;
  logic               valid;
  logic               ready;
  logic               cell_next;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               run_last;
  logic               frame_done;

  modport source (output valid, output cell_next, output out_row, output out_col,
                  output run_last, output frame_done, input ready);
  modport sink (input valid, input cell_next, input out_row, input out_col,
                input run_last, input frame_done, output ready);
endinterface

interface las_cfg_if;
  import las_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [SIZE_CFG_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* hw/rtl/las_line_store.sv */
// las_line_store: column memory holding the two rows above the current one
// bit 0 is row r-1, bit 1 is row r-2; registered read with write forwarding

module las_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data_r,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data
);

  logic [1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule

/* hw/rtl/las_result_buf.sv */
// las_result_buf: two-deep queue of result bundles, drained one word a cycle while out_ch is ready
// depends on las_pkg and las_if

module las_result_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  las_pkg::res_bundle_t load_bundle,
  output logic                 can_take,
  las_res_if.source            out_ch
);
  import las_pkg::*;

  res_bundle_t q_r [0:1];
  logic        hd_r, hd_nxt;
  logic        tl_r, tl_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  res_bundle_t head;
  res_slot_t   sel;
  logic [3:0]  sel_oh;
  logic [3:0]  rest;
  logic        fire;
  logic        push;
  logic        pop;

  assign head     = q_r[hd_r];
  assign can_take = (cnt_r != 2'd2);
  assign push     = load && (load_bundle.mask != 4'd0);

  always_comb begin
    if (head.mask[0]) begin
      sel = SLOT_UP_LEFT;
    end else if (head.mask[1]) begin
      sel = SLOT_UP_HERE;
    end else if (head.mask[2]) begin
      sel = SLOT_CUR_LEFT;
    end else begin
      sel = SLOT_CUR_HERE;
    end
    sel_oh = 4'd1 << sel;
    rest   = head.mask & ~sel_oh;
  end

  assign fire = out_ch.valid && out_ch.ready;
  assign pop  = fire && (rest == 4'd0);

  always_comb begin
    out_ch.valid      = (cnt_r != 2'd0);
    out_ch.cell_next  = head.val[sel];
    out_ch.run_last   = (rest == 4'd0);
    out_ch.frame_done = (sel == SLOT_CUR_HERE);
    case (sel)
      SLOT_UP_LEFT: begin
        out_ch.out_row = head.row_m1;
        out_ch.out_col = head.col_m1;
      end
      SLOT_UP_HERE: begin
        out_ch.out_row = head.row_m1;
        out_ch.out_col = head.col;
      end
      SLOT_CUR_LEFT: begin
        out_ch.out_row = head.row;
        out_ch.out_col = head.col_m1;
      end
      default: begin
        out_ch.out_row = head.row;
        out_ch.out_col = head.col;
      end
    endcase
  end

  always_comb begin
    hd_nxt  = pop ? ~hd_r : hd_r;
    tl_nxt  = push ? ~tl_r : tl_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r  <= 1'b0;
      tl_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      hd_r  <= hd_nxt;
      tl_r  <= tl_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      q_r[hd_r].mask <= rest;
    end
    if (push) begin
      q_r[tl_r] <= load_bundle;
    end
  end

endmodule

/* hw/rtl/life_automaton_stencil_core.sv */
// life_automaton_stencil_core: one B3/S23 generation over a raster cell stream
// depends on las_pkg, las_if, las_line_store and las_result_buf
//
//  channel  dir  word
//  in_ch    in   cell_in
//  out_ch   out  cell_next, out_row, out_col, run_last, frame_done
//  cfg_ch   in   reg_index, wr_data (grid_width, grid_height)
//
// one cell a cycle while in_ch is not stalled: accept reads the line store into
// the s1 registers, then commit counts the window, writes back and queues 0 to 4
// results; each result takes one out word, so cells with several results can stall in_ch
// no clearing pass after reset; reset zeroes counters, window and queues
// out_ch stalls are absorbed by a two-deep result queue before in_ch stalls

module life_automaton_stencil_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  las_cell_if.sink  in_ch,
  las_res_if.source out_ch,
  las_cfg_if.sink   cfg_ch
);
  import las_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [SIZE_W-1:0] COL_LIMIT = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] ROW_LIMIT = SIZE_W'(MAX_ROWS);

  logic [SIZE_CFG_W-1:0] grid_width_r;
  logic [SIZE_CFG_W-1:0] grid_height_r;

  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;

  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_cell_r;
  logic [CW-1:0] s1_c_r;
  logic [RW-1:0] s1_r_r;
  logic          s1_last_col_r;
  logic          s1_last_row_r;

  logic [8:0]    window_r;

  logic [SIZE_W-1:0] w_ext, h_ext, w_last, h_last;
  logic              last_col, last_row;
  logic              in_accept;
  logic              commit;
  logic              can_take;

  logic [1:0]    rd_data;
  logic          up, old;
  logic [2:0]    col3;
  logic [8:0]    win, win_sh;
  logic          r_ge1, r_ge2, c_ge1;
  logic [RW-1:0] r_m1;
  logic [CW-1:0] c_m1;
  logic [RW+COORD_W-1:0] r_x, r_m1_x;
  logic [CW+COORD_W-1:0] c_x, c_m1_x;
  res_bundle_t   bundle;

  // config port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_SIZE_RESET;
      grid_height_r <= GRID_SIZE_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == REG_GRID_WIDTH) begin
        grid_width_r <= cfg_ch.wr_data;
      end
      if (cfg_ch.reg_index == REG_GRID_HEIGHT) begin
        grid_height_r <= cfg_ch.wr_data;
      end
    end
  end

  // effective last indexes
  always_comb begin
    w_ext = SIZE_W'(grid_width_r);
    h_ext = SIZE_W'(grid_height_r);
    if (w_ext == '0) begin
      w_last = '0;
    end else if (w_ext > COL_LIMIT) begin
      w_last = COL_LIMIT - SIZE_W'(1);
    end else begin
      w_last = w_ext - SIZE_W'(1);
    end
    if (h_ext == '0) begin
      h_last = '0;
    end else if (h_ext > ROW_LIMIT) begin
      h_last = ROW_LIMIT - SIZE_W'(1);
    end else begin
      h_last = h_ext - SIZE_W'(1);
    end
    last_col = (SIZE_W'(col_count_r) >= w_last);
    last_row = (SIZE_W'(row_count_r) >= h_last);
  end

  // input side
  assign commit      = s1_valid_r && can_take;
  assign in_ch.ready = !s1_valid_r || commit;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (in_accept) begin
      if (last_col) begin
        col_count_nxt = '0;
        row_count_nxt = last_row ? '0 : row_count_r + RW'(1);
      end else begin
        col_count_nxt = col_count_r + CW'(1);
      end
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (commit) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell_r     <= in_ch.cell_in;
      s1_c_r        <= col_count_r;
      s1_r_r        <= row_count_r;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
    end
  end

  las_line_store #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_store (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr   (col_count_r),
    .rd_data_r (rd_data),
    .wr_en     (commit),
    .wr_addr   (s1_c_r),
    .wr_data   ({rd_data[0], s1_cell_r})
  );

  // window and rule
  always_comb begin
    r_ge1  = (s1_r_r != '0);
    r_ge2  = (s1_r_r > RW'(1));
    c_ge1  = (s1_c_r != '0);
    up     = r_ge1 & rd_data[0];
    old    = r_ge2 & rd_data[1];
    col3   = {s1_cell_r, up, old};
    win    = c_ge1 ? {window_r[5:0], col3} : {6'd0, col3};
    win_sh = {win[5:0], 3'b000};
    r_m1   = s1_r_r - RW'(1);
    c_m1   = s1_c_r - CW'(1);
    r_x    = {{COORD_W{1'b0}}, s1_r_r};
    r_m1_x = {{COORD_W{1'b0}}, r_m1};
    c_x    = {{COORD_W{1'b0}}, s1_c_r};
    c_m1_x = {{COORD_W{1'b0}}, c_m1};

    bundle.mask[SLOT_UP_LEFT]  = r_ge1 && c_ge1;
    bundle.mask[SLOT_UP_HERE]  = r_ge1 && s1_last_col_r;
    bundle.mask[SLOT_CUR_LEFT] = s1_last_row_r && c_ge1;
    bundle.mask[SLOT_CUR_HERE] = s1_last_row_r && s1_last_col_r;
    bundle.val[SLOT_UP_LEFT]   = life_rule(win);
    bundle.val[SLOT_UP_HERE]   = life_rule(win_sh);
    bundle.val[SLOT_CUR_LEFT]  = life_rule(shift_down(win));
    bundle.val[SLOT_CUR_HERE]  = life_rule(shift_down(win_sh));
    bundle.row    = r_x[COORD_W-1:0];
    bundle.row_m1 = r_m1_x[COORD_W-1:0];
    bundle.col    = c_x[COORD_W-1:0];
    bundle.col_m1 = c_m1_x[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (commit) begin
      window_r <= win;
    end
  end

  las_result_buf u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (commit),
    .load_bundle (bundle),
    .can_take    (can_take),
    .out_ch      (out_ch)
  );

endmodule
